>>> src/longest_prefix_match_route_table_top_macros.svh
// Assertion helpers for the route table top level.
`ifndef LONGEST_PREFIX_MATCH_ROUTE_TABLE_TOP_MACROS_SVH
`define LONGEST_PREFIX_MATCH_ROUTE_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lpm_pkg.sv
`default_nettype none

package lpm_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ADDR_W   = 32;
  localparam int PLEN_W   = 6;
  localparam int MAX_PLEN = 32;
  localparam int METRIC_W = 16;
  localparam int KIND_W   = 3;
  localparam int TAG_W    = 16;
  localparam int SLOT_W   = 8;
  localparam int OP_W     = 2;
  localparam int ST_W     = 2;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd3;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_NOROUTE = 2'd2;
  localparam logic [ST_W-1:0] ST_BADSLOT = 2'd3;

  // Full route entry as written on an add.
  typedef struct packed {
    logic [ADDR_W-1:0]   dest;
    logic [PLEN_W-1:0]   prefix;
    logic [ADDR_W-1:0]   hop;
    logic [METRIC_W-1:0] metric;
    logic [KIND_W-1:0]   kind;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  // Fields read back from the table by the sequencer and the matcher.
  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [PLEN_W-1:0] prefix;
    logic [ADDR_W-1:0] hop;
    logic [TAG_W-1:0]  tag;
  } entry_rd_t;

  // One lookup sweep step, aligned with the registered read data.
  typedef struct packed {
    logic             live;
    logic             valid;
    logic [IDX_W-1:0] idx;
  } scan_t;

endpackage

`default_nettype wire

>>> src/longest_prefix_match_route_table_top.sv
`default_nettype none

// Longest-prefix-match route table of 256 entries behind one sequencer. An item is
// taken only while the sequencer is idle and its result is sent through an output
// register. A lookup sweeps the entry memory's single read port one slot per cycle
// through every slot, then passes S_DRAIN and S_DONE before its result is ready.
// An add walks the valid bits from slot 0 to the lowest free slot; a full table
// answers with a full status and no search. A remove reads back the slot's tag
// before its result. The result stays in the output register until taken; the
// next item is accepted after it is loaded.

`include "longest_prefix_match_route_table_top_macros.svh"

module longest_prefix_match_route_table_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [lpm_pkg::OP_W-1:0]        operation,
  input  wire logic [lpm_pkg::ADDR_W-1:0]      address,
  input  wire logic [lpm_pkg::PLEN_W-1:0]      prefix_bits,
  input  wire logic [lpm_pkg::ADDR_W-1:0]      hop_in,
  input  wire logic [lpm_pkg::METRIC_W-1:0]    metric_in,
  input  wire logic [lpm_pkg::KIND_W-1:0]      route_kind,
  input  wire logic [lpm_pkg::TAG_W-1:0]       user_tag_in,
  input  wire logic [lpm_pkg::SLOT_W-1:0]      slot_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [lpm_pkg::ST_W-1:0]             status,
  output logic [lpm_pkg::SLOT_W-1:0]           slot_out,
  output logic [lpm_pkg::ADDR_W-1:0]           hop_out,
  output logic [lpm_pkg::TAG_W-1:0]            user_tag_out
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE,
    S_UPD,
    S_TAG_ADDR,
    S_TAG_WAIT,
    S_SCAN,
    S_DRAIN,
    S_DONE,
    S_RESP
  } state_t;

  state_t                           state;
  logic [lpm_pkg::IDX_W-1:0]        idx;
  logic [lpm_pkg::ADDR_W-1:0]       key;
  lpm_pkg::entry_t                  req_entry;
  logic [lpm_pkg::TABLE_DEPTH-1:0]  valid_bits;
  logic [lpm_pkg::CNT_W-1:0]        entry_count;
  lpm_pkg::scan_t                   scan;

  logic [lpm_pkg::ST_W-1:0]         res_status;
  logic [lpm_pkg::SLOT_W-1:0]       res_slot;
  logic [lpm_pkg::ADDR_W-1:0]       res_hop;
  logic [lpm_pkg::TAG_W-1:0]        res_tag;

  lpm_pkg::entry_rd_t               rd_data;
  logic [lpm_pkg::PLEN_W-1:0]       best_len;
  logic [lpm_pkg::IDX_W-1:0]        best_idx;
  logic [lpm_pkg::ADDR_W-1:0]       best_hop;

  logic                             accept;
  logic [lpm_pkg::IDX_W-1:0]        slot_idx;
  logic                             slot_ok;
  logic                             wr_en;
  logic                             metric_wr_en;
  logic                             match_clear;
  logic [lpm_pkg::PLEN_W-1:0]       plen_clip;

  assign in_ready     = (state == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign slot_idx     = lpm_pkg::IDX_W'(slot_in);
  assign slot_ok      = (32'(slot_in) < lpm_pkg::TABLE_DEPTH) && valid_bits[slot_idx];
  assign wr_en        = (state == S_FREE) && !valid_bits[idx];
  assign metric_wr_en = (state == S_UPD);
  assign match_clear  = accept && (operation == lpm_pkg::OP_LOOKUP);
  assign plen_clip    = (prefix_bits > lpm_pkg::PLEN_W'(lpm_pkg::MAX_PLEN))
                        ? lpm_pkg::PLEN_W'(lpm_pkg::MAX_PLEN) : prefix_bits;

  lpm_entry_mem u_mem (
    .clk          (clk),
    .wr_en        (wr_en),
    .metric_wr_en (metric_wr_en),
    .wr_addr      (idx),
    .wr_data      (req_entry),
    .rd_addr      (idx),
    .rd_data      (rd_data)
  );

  lpm_match u_match (
    .clk      (clk),
    .rst      (rst),
    .clear    (match_clear),
    .scan     (scan),
    .entry    (rd_data),
    .key      (key),
    .best_len (best_len),
    .best_idx (best_idx),
    .best_hop (best_hop)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      valid_bits  <= '0;
      entry_count <= '0;
      scan        <= '0;
      out_valid   <= 1'b0;
    end else begin
      // Align sweep position and valid bit with the registered read data.
      scan.live  <= (state == S_SCAN);
      scan.valid <= valid_bits[idx];
      scan.idx   <= idx;

      if (out_valid && out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            key              <= address;
            req_entry.dest   <= address;
            req_entry.prefix <= plen_clip;
            req_entry.hop    <= hop_in;
            req_entry.metric <= metric_in;
            req_entry.kind   <= route_kind;
            req_entry.tag    <= user_tag_in;
            res_hop          <= '0;
            res_tag          <= '0;
            unique case (operation)
              lpm_pkg::OP_ADD: begin
                res_slot <= '0;
                if (entry_count == lpm_pkg::CNT_W'(lpm_pkg::TABLE_DEPTH)) begin
                  res_status <= lpm_pkg::ST_FULL;
                  state      <= S_RESP;
                end else begin
                  res_status <= lpm_pkg::ST_OK;
                  idx        <= '0;
                  state      <= S_FREE;
                end
              end
              lpm_pkg::OP_REMOVE, lpm_pkg::OP_UPDATE: begin
                if (!slot_ok) begin
                  res_status <= lpm_pkg::ST_BADSLOT;
                  res_slot   <= '0;
                  state      <= S_RESP;
                end else begin
                  res_status <= lpm_pkg::ST_OK;
                  idx        <= slot_idx;
                  res_slot   <= slot_in;
                  if (operation == lpm_pkg::OP_REMOVE) begin
                    valid_bits[slot_idx] <= 1'b0;
                    entry_count          <= entry_count - 1'b1;
                    state                <= S_TAG_ADDR;
                  end else begin
                    state <= S_UPD;
                  end
                end
              end
              lpm_pkg::OP_LOOKUP: begin
                res_status <= lpm_pkg::ST_OK;
                res_slot   <= '0;
                idx        <= '0;
                state      <= S_SCAN;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_FREE: begin
          if (!valid_bits[idx]) begin
            valid_bits[idx] <= 1'b1;
            entry_count     <= entry_count + 1'b1;
            res_slot        <= lpm_pkg::SLOT_W'(idx);
            state           <= S_RESP;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_UPD: begin
          state <= S_RESP;
        end
        S_TAG_ADDR: begin
          state <= S_TAG_WAIT;
        end
        S_TAG_WAIT: begin
          res_tag <= rd_data.tag;
          state   <= S_RESP;
        end
        S_SCAN: begin
          idx <= idx + 1'b1;
          if (idx == lpm_pkg::IDX_W'(lpm_pkg::TABLE_DEPTH - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (best_len == '0) begin
            res_status <= lpm_pkg::ST_NOROUTE;
          end else begin
            res_slot <= lpm_pkg::SLOT_W'(best_idx);
            res_hop  <= best_hop;
          end
          state <= S_RESP;
        end
        S_RESP: begin
          // Hold the result until the output register is free.
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            slot_out     <= res_slot;
            hop_out      <= res_hop;
            user_tag_out <= res_tag;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `LPM_ASSERT_NOW(a_count_matches_valid, 1'b1, entry_count == lpm_pkg::CNT_W'($countones(valid_bits)), "entry count out of step with valid bits")
  `LPM_ASSERT_NOW(a_free_scan_has_room, state == S_FREE, entry_count < lpm_pkg::CNT_W'(lpm_pkg::TABLE_DEPTH), "free-slot search on a full table")
  `LPM_ASSERT_NEXT(a_busy_after_transfer, accept, !in_ready, "input ready right after a transfer")
  `LPM_ASSERT_NOW(a_noroute_zero_hop, out_valid && status == lpm_pkg::ST_NOROUTE, hop_out == '0 && slot_out == '0, "no-route result carries a hop or slot")

endmodule

`default_nettype wire

>>> src/lpm_entry_mem.sv
`default_nettype none

module lpm_entry_mem (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic                          metric_wr_en,
  input  wire logic [lpm_pkg::IDX_W-1:0]     wr_addr,
  input  wire lpm_pkg::entry_t               wr_data,
  input  wire logic [lpm_pkg::IDX_W-1:0]     rd_addr,
  output lpm_pkg::entry_rd_t                 rd_data
);

  logic [lpm_pkg::ADDR_W-1:0]   dest_mem   [lpm_pkg::TABLE_DEPTH];
  logic [lpm_pkg::PLEN_W-1:0]   prefix_mem [lpm_pkg::TABLE_DEPTH];
  logic [lpm_pkg::ADDR_W-1:0]   hop_mem    [lpm_pkg::TABLE_DEPTH];
  logic [lpm_pkg::METRIC_W-1:0] metric_mem [lpm_pkg::TABLE_DEPTH];
  logic [lpm_pkg::KIND_W-1:0]   kind_mem   [lpm_pkg::TABLE_DEPTH];
  logic [lpm_pkg::TAG_W-1:0]    tag_mem    [lpm_pkg::TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dest_mem[wr_addr]   <= wr_data.dest;
      prefix_mem[wr_addr] <= wr_data.prefix;
      hop_mem[wr_addr]    <= wr_data.hop;
      kind_mem[wr_addr]   <= wr_data.kind;
      tag_mem[wr_addr]    <= wr_data.tag;
    end
    if (wr_en || metric_wr_en) begin
      metric_mem[wr_addr] <= wr_data.metric;
    end
  end

  always_ff @(posedge clk) begin
    rd_data.dest   <= dest_mem[rd_addr];
    rd_data.prefix <= prefix_mem[rd_addr];
    rd_data.hop    <= hop_mem[rd_addr];
    rd_data.tag    <= tag_mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> src/lpm_match.sv
`default_nettype none

module lpm_match (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          clear,
  input  wire lpm_pkg::scan_t                scan,
  input  wire lpm_pkg::entry_rd_t            entry,
  input  wire logic [lpm_pkg::ADDR_W-1:0]    key,
  output logic [lpm_pkg::PLEN_W-1:0]         best_len,
  output logic [lpm_pkg::IDX_W-1:0]          best_idx,
  output logic [lpm_pkg::ADDR_W-1:0]         best_hop
);

  logic [lpm_pkg::PLEN_W-1:0] shamt;
  logic [lpm_pkg::ADDR_W-1:0] mask;
  logic                       hit;

  // Top prefix bits only; a shift by the full width leaves an empty mask.
  assign shamt = lpm_pkg::PLEN_W'(lpm_pkg::ADDR_W) - entry.prefix;
  assign mask  = {lpm_pkg::ADDR_W{1'b1}} << shamt;
  assign hit   = scan.live && scan.valid && (((key ^ entry.dest) & mask) == '0)
                 && (entry.prefix > best_len);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best_len <= '0;
      best_idx <= '0;
      best_hop <= '0;
    end else if (hit) begin
      best_len <= entry.prefix;
      best_idx <= scan.idx;
      best_hop <= entry.hop;
    end
  end

endmodule

`default_nettype wire
